FILE: sv/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Types and constants shared by the longest palindrome finder.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int MAX_LINE = 256;
  localparam int ADDR_W   = $clog2(MAX_LINE);
  localparam int CNT_W    = $clog2(MAX_LINE + 1);

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [8:0] pal_length;
    logic [7:0] pal_begin;
    logic [7:0] pal_end;
  } out_word_t;

endpackage

FILE: sv/lpf_ram.sv
// ----------------------------------------------------------------------------
// lpf_ram
// Line buffer: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lpf_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [lpf_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic [lpf_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [lpf_pkg::ADDR_W-1:0] rd_addr_b,
  output logic [7:0]                 rd_data_a,
  output logic [7:0]                 rd_data_b
);
  import lpf_pkg::*;

  logic [7:0] mem [MAX_LINE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: sv/longest_palindrome_finder_core.sv
// ----------------------------------------------------------------------------
// longest_palindrome_finder_core
// Stores a line of bytes and searches it for its longest palindrome by
// expanding around every centre.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word
//  --------+-----------+-----------------------------------------
//  in      | input     | char_in, last_char
//  out     | output    | pal_length, pal_begin, pal_end
//
// Ordinary bytes are written into the line buffer while the core loads.
// After the final byte the search tries byte pairs: both bytes of a pair are
// read from the line buffer in the issue state and compared in the compare
// state, then the result is handed over in the done state. The two-port read
// of the line buffer lets both bytes of a pair be read together. Reset is
// synchronous and clears the control state; the buffer itself is not
// cleared. The next line is taken while a result still waits under a stall.
// ----------------------------------------------------------------------------
module longest_palindrome_finder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lpf_pkg::out_word_t out_data
);
  import lpf_pkg::*;

  localparam logic [1:0] S_LOAD    = 2'd0;
  localparam logic [1:0] S_ISSUE   = 2'd1;
  localparam logic [1:0] S_COMPARE = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] centre;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic             even;
  logic [CNT_W-1:0] best_len;
  logic [CNT_W-1:0] best_start;

  logic             in_fire;
  logic             wr_en;
  logic [7:0]       d_lo;
  logic [7:0]       d_hi;
  logic             advance;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] centre_next;

  assign in_stall    = (state != S_LOAD);
  assign in_fire     = in_valid && !in_stall;
  assign wr_en       = in_fire && (fill_count < CNT_W'(MAX_LINE));
  assign run_len     = hi - lo + CNT_W'(1);
  assign centre_next = centre + CNT_W'(1);

  always_comb begin
    case (state)
      S_ISSUE:   advance = (hi >= n);
      S_COMPARE: advance = (d_lo != d_hi) || (lo == '0);
      default:   advance = 1'b0;
    endcase
  end

  lpf_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (fill_count[ADDR_W-1:0]),
    .wr_data   (in_data.char_in),
    .rd_addr_a (lo[ADDR_W-1:0]),
    .rd_addr_b (hi[ADDR_W-1:0]),
    .rd_data_a (d_lo),
    .rd_data_b (d_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (wr_en) begin
              fill_count <= fill_count + CNT_W'(1);
            end
            if (in_data.last_char) begin
              n          <= wr_en ? fill_count + CNT_W'(1) : fill_count;
              fill_count <= '0;
              centre     <= '0;
              lo         <= '0;
              hi         <= '0;
              even       <= 1'b0;
              best_len   <= '0;
              best_start <= '0;
              state      <= S_ISSUE;
            end
          end
        end
        S_ISSUE, S_COMPARE: begin
          if ((state == S_COMPARE) && (d_lo == d_hi) && (run_len > best_len)) begin
            best_len   <= run_len;
            best_start <= lo;
          end
          if (advance) begin
            if (!even) begin
              even  <= 1'b1;
              lo    <= centre;
              hi    <= centre_next;
              state <= S_ISSUE;
            end else if (centre_next >= n) begin
              state <= S_DONE;
            end else begin
              centre <= centre_next;
              lo     <= centre_next;
              hi     <= centre_next;
              even   <= 1'b0;
              state  <= S_ISSUE;
            end
          end else if (state == S_ISSUE) begin
            state <= S_COMPARE;
          end else begin
            lo    <= lo - CNT_W'(1);
            hi    <= hi + CNT_W'(1);
            state <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_data.pal_length <= 9'(best_len);
            out_data.pal_begin  <= 8'(best_start);
            out_data.pal_end    <= 8'(best_start + best_len - CNT_W'(1));
            state               <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
